[sv/pvu_pkg.sv]
// shared constants, command and status types and arithmetic helpers for the pdhg vector update
package pvu_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int VAL_W      = 32;
    localparam int WIDE_W     = 51;
    localparam int REG_W      = 31;
    localparam int SUM_W      = 63;
    localparam int MUL_A_W    = VAL_W + 1;
    localparam int MUL_B_W    = VAL_W;
    localparam int MUL_W      = MUL_A_W + MUL_B_W;
    localparam int DIVD_W     = 64;
    localparam int DIVS_W     = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 160;
    localparam logic [REG_W-1:0] REG_RESET = REG_W'(65536);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TAU   = 2'd0,
        CFG_SIGMA = 2'd1,
        CFG_OMEGA = 2'd2
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_GRAD,
        OP_PNEXT,
        OP_SQ,
        OP_WLO,
        OP_WHI,
        OP_PTERM,
        OP_DMUL,
        OP_DV,
        OP_DIVQ,
        OP_DQ,
        OP_DCMUL,
        OP_DNEXT,
        OP_DIVT,
        OP_DTERM,
        OP_EMIT
    } pvu_op_t;

    typedef struct packed {
        pvu_op_t op;
        logic    in_ready;
    } pvu_cmd_t;

    typedef struct packed {
        logic mode;
        logic div_done;
        logic out_free;
    } pvu_stat_t;

    // sign extend a value field to the internal wide format
    function automatic logic signed [WIDE_W-1:0] wext(input logic signed [VAL_W-1:0] v);
        return {{(WIDE_W-VAL_W){v[VAL_W-1]}}, v};
    endfunction

    // saturate a wide value to the value range
    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] vmax;
        logic signed [WIDE_W-1:0] vmin;
        vmax = {{(WIDE_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
        vmin = ~vmax;
        if (v > vmax)
            return vmax[VAL_W-1:0];
        if (v < vmin)
            return vmin[VAL_W-1:0];
        return v[VAL_W-1:0];
    endfunction

    // box clamp, lower bound tested first
    function automatic logic signed [WIDE_W-1:0] clampb(
        input logic signed [WIDE_W-1:0] v,
        input logic signed [VAL_W-1:0]  lo,
        input logic signed [VAL_W-1:0]  hi,
        input logic                     lo_en,
        input logic                     hi_en
    );
        if (lo_en && (v < wext(lo)))
            return wext(lo);
        if (hi_en && (v > wext(hi)))
            return wext(hi);
        return v;
    endfunction

    // product shifted right by the fraction bits, rounded half up on the magnitude
    function automatic logic signed [WIDE_W-1:0] round_mag(input logic [MUL_W-1:0] p);
        logic [MUL_W:0] r;
        r = {1'b0, p} + ((MUL_W+1)'(1) << (FRAC_BITS-1));
        return {1'b0, r[FRAC_BITS +: WIDE_W-1]};
    endfunction

endpackage

[sv/pvu_div.sv]
// serial restoring divider, one quotient bit per cycle
module pvu_div
    import pvu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic [DIVD_W-1:0] quotient,
    output logic              done
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W-1:0] dvs_reg;
    logic [DIVS_W:0]   rem_sh;
    logic [DIVS_W:0]   rem_sub;
    logic              ge;

    assign rem_sh  = {rem_reg, quo_reg[DIVD_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DIVD_W);
            rem_next = '0;
            quo_next = dividend;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
            rem_next  = ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
            quo_next  = {quo_reg[DIVD_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
            dvs_reg <= divisor;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[sv/pvu_dpath.sv]
// datapath: config registers, operand latch, shared multiplier, divider and result register
module pvu_dpath
    import pvu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pvu_cmd_t              cmd,
    output pvu_stat_t             stat,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [REG_W-1:0]      cfg_wdata,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic                  in_mode,
    input  logic                  in_last,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_last
);

    localparam logic [SUM_W-1:0] SUM_CAP = '1;

    logic [REG_W-1:0] tau_reg, sigma_reg, omega_reg;
    logic [REG_W-1:0] sigma_eff, omega_eff;

    logic                    mode_reg, last_reg, lf_reg, uf_reg;
    logic signed [VAL_W-1:0] cur_reg, cost_reg, prod_reg, lb_reg, ub_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_en;
    logic [MUL_W-1:0]   mul_reg;
    logic               neg_reg;
    logic [DIVD_W-1:0]  dd_reg, lo_reg;

    logic signed [WIDE_W-1:0] acc_reg;
    logic signed [VAL_W-1:0]  next_reg, c_reg;
    logic [SUM_W-1:0]         term_reg, sum_reg;

    logic                    out_valid_reg, out_last_reg;
    logic signed [VAL_W-1:0] o_next_reg, o_extra_reg, o_diff_reg;
    logic [SUM_W-1:0]        o_total_reg;

    logic signed [VAL_W:0]    gsum, pext, cext, dval;
    logic [MUL_A_W-1:0]       gmag, pmag, cmag;
    logic [VAL_W-1:0]         dmag;
    logic signed [WIDE_W-1:0] m_mag, sm, t_pr, vmag;
    logic [32:0]              qm;
    logic signed [WIDE_W-1:0] qs;
    logic [96:0]              pw;
    logic [SUM_W:0]           sum_add;
    logic [SUM_W-1:0]         sum_sat;

    logic              div_start;
    logic [DIVD_W-1:0] div_n;
    logic [DIVS_W-1:0] div_d;
    logic [DIVD_W-1:0] quo;
    logic              div_done;

    assign sigma_eff = (sigma_reg == '0) ? REG_W'(1) : sigma_reg;
    assign omega_eff = (omega_reg == '0) ? REG_W'(1) : omega_reg;

    // operand magnitudes
    assign gsum = {cost_reg[VAL_W-1], cost_reg} + {prod_reg[VAL_W-1], prod_reg};
    assign gmag = gsum[VAL_W] ? MUL_A_W'(-gsum) : MUL_A_W'(gsum);
    assign pext = {prod_reg[VAL_W-1], prod_reg};
    assign pmag = pext[VAL_W] ? MUL_A_W'(-pext) : MUL_A_W'(pext);
    assign cext = {c_reg[VAL_W-1], c_reg};
    assign cmag = cext[VAL_W] ? MUL_A_W'(-cext) : MUL_A_W'(cext);
    assign dval = {next_reg[VAL_W-1], next_reg} - {cur_reg[VAL_W-1], cur_reg};
    assign dmag = dval[VAL_W] ? VAL_W'(-dval) : VAL_W'(dval);

    // rounded scaled product with its sign restored
    assign m_mag = round_mag(mul_reg);
    assign sm    = neg_reg ? -m_mag : m_mag;
    assign t_pr  = wext(cur_reg) - sm;
    assign vmag  = acc_reg[WIDE_W-1] ? -acc_reg : acc_reg;

    // v/sigma capped at the value range
    assign qm = (quo > DIVD_W'(64'h8000_0000)) ? 33'h0_8000_0000 : quo[32:0];
    always_comb
    begin
        if (acc_reg[WIDE_W-1])
            qs = -{{(WIDE_W-33){1'b0}}, qm};
        else if (qm > 33'h0_7FFF_FFFF)
            qs = {{(WIDE_W-33){1'b0}}, 33'h0_7FFF_FFFF};
        else
            qs = {{(WIDE_W-33){1'b0}}, qm};
    end

    assign pw = {1'b0, mul_reg[63:0], 32'b0} + {33'b0, lo_reg} + (97'd1 << 32);

    assign sum_add = {1'b0, sum_reg} + {1'b0, term_reg};
    assign sum_sat = sum_add[SUM_W] ? SUM_CAP : sum_add[SUM_W-1:0];

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            OP_GRAD:
            begin
                mul_a = gmag;
                mul_b = {1'b0, tau_reg};
            end
            OP_DMUL:
            begin
                mul_a = pmag;
                mul_b = {1'b0, sigma_eff};
            end
            OP_DCMUL:
            begin
                mul_a = cmag;
                mul_b = {1'b0, sigma_eff};
            end
            OP_SQ:
            begin
                mul_a = {1'b0, dmag};
                mul_b = dmag;
            end
            OP_WLO:
            begin
                mul_a = {1'b0, mul_reg[31:0]};
                mul_b = {1'b0, omega_eff};
            end
            OP_WHI:
            begin
                mul_a = {1'b0, dd_reg[63:32]};
                mul_b = {1'b0, omega_eff};
            end
            default:
                mul_en = 1'b0;
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        case (cmd.op)
            OP_DIVQ:
            begin
                div_start = 1'b1;
                div_n     = {vmag[47:0], {FRAC_BITS{1'b0}}};
                div_d     = {1'b0, sigma_eff};
            end
            OP_DIVT:
            begin
                div_start = 1'b1;
                div_n     = mul_reg[63:0];
                div_d     = {omega_eff, 1'b0};
            end
            default:
                div_start = 1'b0;
        endcase
    end

    pvu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quotient (quo),
        .done     (div_done)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tau_reg   <= REG_RESET;
            sigma_reg <= REG_RESET;
            omega_reg <= REG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_TAU:   tau_reg   <= cfg_wdata;
                CFG_SIGMA: sigma_reg <= cfg_wdata;
                CFG_OMEGA: omega_reg <= cfg_wdata;
                default:   tau_reg   <= tau_reg;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (mul_en)
            mul_reg <= MUL_W'(mul_a) * MUL_W'(mul_b);
        case (cmd.op)
            OP_LOAD:
            begin
                mode_reg <= in_mode;
                last_reg <= in_last;
                cur_reg  <= in_data[31:0];
                cost_reg <= in_data[63:32];
                prod_reg <= in_data[95:64];
                lb_reg   <= in_data[127:96];
                ub_reg   <= in_data[159:128];
                lf_reg   <= in_data[160];
                uf_reg   <= in_data[161];
            end
            OP_GRAD:  neg_reg  <= gsum[VAL_W];
            OP_DMUL:  neg_reg  <= prod_reg[VAL_W-1];
            OP_DCMUL: neg_reg  <= c_reg[VAL_W-1];
            OP_PNEXT: next_reg <= sat_val(clampb(t_pr, lb_reg, ub_reg, lf_reg, uf_reg));
            OP_DV:    acc_reg  <= wext(cur_reg) + sm;
            OP_DQ:    c_reg    <= VAL_W'(clampb(qs, lb_reg, ub_reg, lf_reg, uf_reg));
            OP_DNEXT: next_reg <= sat_val(acc_reg - sm);
            OP_WLO:   dd_reg   <= mul_reg[63:0];
            OP_WHI:   lo_reg   <= mul_reg[63:0];
            OP_PTERM: term_reg <= pw[95:33];
            OP_DTERM: term_reg <= quo[63] ? SUM_CAP : quo[62:0];
            default:  neg_reg  <= neg_reg;
        endcase
    end

    // running movement sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (cmd.op == OP_EMIT)
            sum_reg <= last_reg ? '0 : sum_sat;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_EMIT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EMIT)
        begin
            o_next_reg   <= next_reg;
            o_extra_reg  <= mode_reg ? '0 :
                            sat_val((wext(next_reg) <<< 1) - wext(cur_reg));
            o_diff_reg   <= sat_val({{(WIDE_W-VAL_W-1){dval[VAL_W]}}, dval});
            o_total_reg  <= last_reg ? sum_sat : '0;
            out_last_reg <= last_reg;
        end
    end

    assign stat.mode     = mode_reg;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_data  = {1'b0, o_total_reg, o_diff_reg, o_extra_reg, o_next_reg};

endmodule

[sv/pvu_ctrl.sv]
// controller: sequences the primal and dual update steps over the datapath
module pvu_ctrl
    import pvu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  pvu_stat_t stat,
    output pvu_cmd_t  cmd
);

    typedef enum logic [17:0] {
        S_IDLE  = 18'h1 << 0,
        S_START = 18'h1 << 1,
        S_PNEXT = 18'h1 << 2,
        S_PSQ   = 18'h1 << 3,
        S_WLO   = 18'h1 << 4,
        S_WHI   = 18'h1 << 5,
        S_PTERM = 18'h1 << 6,
        S_DV    = 18'h1 << 7,
        S_DIVQ  = 18'h1 << 8,
        S_QWAIT = 18'h1 << 9,
        S_DQ    = 18'h1 << 10,
        S_DCMUL = 18'h1 << 11,
        S_DNEXT = 18'h1 << 12,
        S_DSQ   = 18'h1 << 13,
        S_DIVT  = 18'h1 << 14,
        S_TWAIT = 18'h1 << 15,
        S_DTERM = 18'h1 << 16,
        S_EMIT  = 18'h1 << 17
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.op     = stat.mode ? OP_DMUL : OP_GRAD;
                state_next = stat.mode ? S_DV : S_PNEXT;
            end
            S_PNEXT:
            begin
                cmd.op     = OP_PNEXT;
                state_next = S_PSQ;
            end
            S_PSQ:
            begin
                cmd.op     = OP_SQ;
                state_next = S_WLO;
            end
            S_WLO:
            begin
                cmd.op     = OP_WLO;
                state_next = S_WHI;
            end
            S_WHI:
            begin
                cmd.op     = OP_WHI;
                state_next = S_PTERM;
            end
            S_PTERM:
            begin
                cmd.op     = OP_PTERM;
                state_next = S_EMIT;
            end
            S_DV:
            begin
                cmd.op     = OP_DV;
                state_next = S_DIVQ;
            end
            S_DIVQ:
            begin
                cmd.op     = OP_DIVQ;
                state_next = S_QWAIT;
            end
            S_QWAIT:
            begin
                if (stat.div_done)
                    state_next = S_DQ;
            end
            S_DQ:
            begin
                cmd.op     = OP_DQ;
                state_next = S_DCMUL;
            end
            S_DCMUL:
            begin
                cmd.op     = OP_DCMUL;
                state_next = S_DNEXT;
            end
            S_DNEXT:
            begin
                cmd.op     = OP_DNEXT;
                state_next = S_DSQ;
            end
            S_DSQ:
            begin
                cmd.op     = OP_SQ;
                state_next = S_DIVT;
            end
            S_DIVT:
            begin
                cmd.op     = OP_DIVT;
                state_next = S_TWAIT;
            end
            S_TWAIT:
            begin
                if (stat.div_done)
                    state_next = S_DTERM;
            end
            S_DTERM:
            begin
                cmd.op     = OP_DTERM;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[sv/pdhg_vector_update_unit.sv]
// top level of the pdhg vector update unit: stream ports, config port, controller and datapath
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tdata: operands and bounds, tuser: mode, tlast: last element
// m_*      out  m_tvalid/m_tready  tdata: next, extrapolated, difference, movement total
// cfg_*    in   cfg_we             cfg_addr: register index, cfg_wdata: register value
//
// one beat is worked on at a time; s_tready is high only while the controller is idle
// a dual beat makes two passes through the shared one-bit-per-cycle divider
// the result register lets the next beat be accepted while a result waits on m_tready
// rst_n is asynchronous active low and restores step sizes and weight to 1.0 and the sum to 0
module pdhg_vector_update_unit
    import pvu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // current_value, cost_value, product_value, lower_bound, upper_bound,
    // lower_finite, upper_finite, zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // mode
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // next_value, extrapolated_value, difference, movement_total, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [REG_W-1:0]      cfg_wdata
);

    pvu_cmd_t  cmd;
    pvu_stat_t stat;

    // controller only sees the input valid; the datapath latches the beat on load
    pvu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    pvu_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .in_mode   (s_tuser),
        .in_last   (s_tlast),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

    assign s_tready = cmd.in_ready;

endmodule

[verif/pdhg_vector_update_unit_tb.sv]
// self-checking testbench for the pdhg vector update unit: directed, swept-config and random beats
module pdhg_vector_update_unit_tb;
    import pvu_pkg::*;

    localparam int  HALF_PERIOD = 2;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  DRAIN_WAIT  = 200;
    localparam int  HOLD_CYCLES = 600;
    localparam longint VMAX     = 64'sh7FFF_FFFF;
    localparam longint VMIN     = -64'sh8000_0000;
    localparam logic [63:0] PROD_CAP = 64'h2000_0000_0000_0000;
    localparam logic [63:0] SUM_CAP  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [30:0] REG_MAX  = 31'h7FFF_FFFF;

    // one input beat, field by field
    typedef struct {
        logic               mode;
        logic signed [31:0] cur;
        logic signed [31:0] cost;
        logic signed [31:0] prod;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic               lo_en;
        logic               hi_en;
        logic               last;
    } elem_t;

    // one result beat
    typedef struct {
        logic [31:0] next_val;
        logic [31:0] extra_val;
        logic [31:0] diff_val;
        logic [62:0] total;
        logic        is_last;
    } upd_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [REG_W-1:0]      cfg_wdata = '0;

    // predictor state: registers and running movement sum
    logic [30:0] tau_q, sigma_q, omega_q;
    logic [63:0] move_acc;
    upd_t        pending_updates[$];

    int  errors = 0;
    int  cycles = 0;
    bit  no_idle = 1'b0;   // last part of the run: no gaps, no stalls
    bit  hold_go = 1'b0;   // asks the receiver for one long hold-off
    logic holding = 1'b0;
    int  stall_left = 0;

    pdhg_vector_update_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------- arithmetic of the unit

    function automatic logic [63:0] mag64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint sat32(input longint v);
        if (v > VMAX)
            return VMAX;
        if (v < VMIN)
            return VMIN;
        return v;
    endfunction

    // round(a*b / 2^s) half up on the magnitude, capped
    function automatic logic [63:0] scaled_mag(input logic [63:0] a, input logic [63:0] b,
                                               input int s, input logic [63:0] cap);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = (p + (128'd1 << (s - 1))) >> s;
        if (p > {64'd0, cap})
            return cap;
        return p[63:0];
    endfunction

    // signed value times unsigned Q15.16 register
    function automatic longint scale_signed(input longint v, input logic [30:0] r);
        logic [63:0] m;
        m = scaled_mag(mag64(v), {33'd0, r}, FRAC_BITS, PROD_CAP);
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    // box projection, lower bound checked first so it wins when the bounds cross and the value lies below it
    function automatic longint box(input longint v, input elem_t e);
        if (e.lo_en && v < longint'(e.lo))
            return longint'(e.lo);
        if (e.hi_en && v > longint'(e.hi))
            return longint'(e.hi);
        return v;
    endfunction

    // expected result of one element; advances the movement sum
    function automatic upd_t pdhg_update(input elem_t e);
        upd_t        u;
        longint      cur, nxt, extra, d, v, q;
        logic [63:0] sig, omg, dm, term, vm, qi, rem, qm;
        logic [64:0] acc;
        cur   = longint'(e.cur);
        sig   = (sigma_q == 0) ? 64'd1 : {33'd0, sigma_q};
        omg   = (omega_q == 0) ? 64'd1 : {33'd0, omega_q};
        extra = 0;
        if (!e.mode)
        begin
            nxt   = sat32(box(cur - scale_signed(longint'(e.cost) + longint'(e.prod), tau_q), e));
            extra = sat32(2 * nxt - cur);
            d     = nxt - cur;
            dm    = mag64(d);
            if (dm >> 32)
                term = SUM_CAP;
            else
                term = scaled_mag(dm * dm, omg, 2 * FRAC_BITS + 1, SUM_CAP);
        end
        else
        begin
            v   = cur + scale_signed(longint'(e.prod), sig[30:0]);
            vm  = mag64(v);
            qi  = vm / sig;
            rem = vm % sig;
            // quotient saturates to the value range before the projection
            if (qi > (64'(VMAX) >> FRAC_BITS))
                qm = 64'(VMAX) + 1;
            else
                qm = (qi << FRAC_BITS) + ((rem << FRAC_BITS) / sig);
            if (qm > 64'(VMAX) + 1)
                qm = 64'(VMAX) + 1;
            if (v < 0)
                q = -longint'(qm);
            else
                q = (qm > 64'(VMAX)) ? VMAX : longint'(qm);
            q   = sat32(q);
            nxt = sat32(v - scale_signed(box(q, e), sig[30:0]));
            d   = nxt - cur;
            dm  = mag64(d);
            if (dm >> 32)
                term = SUM_CAP;
            else
                term = (dm * dm) / (2 * omg);
            if (term > SUM_CAP)
                term = SUM_CAP;
        end
        acc      = {1'b0, move_acc} + {1'b0, term};
        move_acc = (acc > {1'b0, SUM_CAP}) ? SUM_CAP : acc[63:0];
        u.next_val  = 32'(nxt);
        u.extra_val = 32'(extra);
        u.diff_val  = 32'(sat32(d));
        u.is_last   = e.last;
        u.total     = '0;
        if (e.last)
        begin
            u.total  = move_acc[62:0];
            move_acc = '0;
        end
        return u;
    endfunction

    // ---------------------------------------------------------------- sender

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2:    return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            3:    return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            4:    return ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h0000_2000)) - 32'sh0000_1000;
        endcase
    endfunction

    function automatic elem_t rand_elem(input int dual_pct);
        elem_t e;
        logic signed [31:0] a, b;
        e.mode  = ($urandom_range(0, 99) < dual_pct);
        e.cur   = rand_value();
        e.cost  = rand_value();
        e.prod  = rand_value();
        a       = rand_value();
        b       = rand_value();
        // mostly ordered bounds, now and then crossed
        if ($urandom_range(0, 7) != 0 && a > b)
        begin
            e.lo = b;
            e.hi = a;
        end
        else
        begin
            e.lo = a;
            e.hi = b;
        end
        e.lo_en = $urandom_range(0, 3) != 0;
        e.hi_en = $urandom_range(0, 3) != 0;
        e.last  = $urandom_range(0, 7) == 0;
        return e;
    endfunction

    // offer one beat, wait for its handshake, then book its expected result
    task automatic send_elem(input elem_t e);
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= e.mode;
        s_tlast  <= e.last;
        s_tdata  <= {6'd0, e.hi_en, e.lo_en, e.hi, e.lo, e.prod, e.cost, e.cur};
        do
            @(posedge clk);
        while (!s_tready);
        pending_updates.push_back(pdhg_update(e));
    endtask

    task automatic send_random(input int count, input int dual_pct);
        repeat (count) send_elem(rand_elem(dual_pct));
    endtask

    // stop offering and let every result come back before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_updates.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [30:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TAU:   tau_q   = val;
            CFG_SIGMA: sigma_q = val;
            default:   omega_q = val;
        endcase
    endtask

    task automatic set_regs(input logic [30:0] tau, input logic [30:0] sigma,
                            input logic [30:0] omega);
        write_reg(CFG_TAU, tau);
        write_reg(CFG_SIGMA, sigma);
        write_reg(CFG_OMEGA, omega);
    endtask

    function automatic elem_t mk(input logic mode, input logic signed [31:0] cur,
                                 input logic signed [31:0] cost, input logic signed [31:0] prod,
                                 input logic signed [31:0] lo, input logic signed [31:0] hi,
                                 input logic lo_en, input logic hi_en, input logic last);
        elem_t e;
        e.mode = mode; e.cur = cur; e.cost = cost; e.prod = prod;
        e.lo = lo; e.hi = hi; e.lo_en = lo_en; e.hi_en = hi_en; e.last = last;
        return e;
    endfunction

    // ---------------------------------------------------------------- tests

    // reset register values, field extremes, both modes, clamps and saturations
    task automatic test_directed();
        // primal, no bounds, plain step
        send_elem(mk(0, 32'sh0001_0000, 32'sh0000_8000, 32'sh0000_8000, 0, 0, 0, 0, 0));
        // primal, lower bound pulls the value up
        send_elem(mk(0, 0, 32'sh0010_0000, 0, -32'sh0000_4000, 32'sh0001_0000, 1, 1, 0));
        // primal, upper bound pulls it down
        send_elem(mk(0, 0, -32'sh0010_0000, 0, -32'sh0001_0000, 32'sh0000_4000, 1, 1, 1));
        // crossed bounds: lower wins below it, upper applies above both
        send_elem(mk(0, 0, 32'sh0010_0000, 0, 32'sh0002_0000, -32'sh0002_0000, 1, 1, 0));
        send_elem(mk(0, 0, -32'sh0010_0000, 0, 32'sh0002_0000, -32'sh0002_0000, 1, 1, 1));
        // extreme operands: result and extrapolation saturate
        send_elem(mk(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0, 0));
        send_elem(mk(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0));
        // huge movement terms feed the running sum
        send_elem(mk(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0, 0));
        send_elem(mk(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 0, 1));
        // dual, inside the box and outside both sides
        send_elem(mk(1, 32'sh0000_8000, 0, 32'sh0000_4000, -32'sh0001_0000, 32'sh0001_0000,
                     1, 1, 0));
        send_elem(mk(1, 32'sh0005_0000, 0, 32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000,
                     1, 1, 0));
        send_elem(mk(1, -32'sh0005_0000, 0, -32'sh0001_0000, -32'sh0001_0000,
                     32'sh0001_0000, 1, 1, 1));
        // dual extremes: quotient saturates both ways, unbounded and crossed
        send_elem(mk(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0));
        send_elem(mk(1, 32'sh8000_0000, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                     1, 1, 0));
        send_elem(mk(1, 32'sh8000_0000, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                     1, 1, 1));
        send_elem(mk(1, -1, -1, -1, -1, -1, 1, 1, 1));
        drain();
    endtask

    // register settings at the extremes and between, then a random setting, random beats under each
    task automatic test_config_sweep();
        logic [30:0] tau_set[6]   = '{31'd1, REG_MAX, 31'd65536, 31'd4096, 31'd300000, 31'd1};
        logic [30:0] sigma_set[6] = '{REG_MAX, 31'd1, 31'd65536, 31'd200000, 31'd16, 31'd1};
        logic [30:0] omega_set[6] = '{31'd1, REG_MAX, 31'd65536, 31'd1000, 31'd9000000,
                                      REG_MAX};
        for (int i = 0; i < 6; i++)
        begin
            set_regs(tau_set[i], sigma_set[i], omega_set[i]);
            send_random(180, 25);
            drain();
        end
        set_regs(31'($urandom_range(1, REG_MAX)), 31'($urandom_range(1, REG_MAX)),
                 31'($urandom_range(1, REG_MAX)));
        send_random(120, 25);
        drain();
    endtask

    // long receiver hold-off while beats keep coming, so the input stalls
    task automatic test_backpressure();
        set_regs(31'd65536, 31'd65536, 31'd65536);
        hold_go = 1'b1;
        send_random(40, 10);
        drain();
    endtask

    // closing stretch at full rate, no gaps on either side
    task automatic test_full_rate();
        set_regs(31'($urandom_range(1, 31'h0004_0000)), 31'($urandom_range(1, 31'h0004_0000)),
                 31'($urandom_range(1, 31'h0004_0000)));
        no_idle = 1'b1;
        send_random(300, 20);
        s_tvalid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- receiver and checker

    // one long hold-off, counted here
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (holding)
            m_tready <= 1'b0;
        else if (no_idle)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end
        else
            m_tready <= 1'b1;
    end

    task automatic report(input string field, input logic [63:0] got, input logic [63:0] exp);
        errors++;
        $display("mismatch at cycle %0d: %s got %h expected %h", cycles, field, got, exp);
    endtask

    always @(posedge clk)
    begin
        upd_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_updates.size() == 0)
                report("unexpected beat", m_tdata[63:0], 64'd0);
            else
            begin
                e = pending_updates.pop_front();
                if (m_tdata[31:0] !== e.next_val)
                    report("next_value", m_tdata[31:0], e.next_val);
                if (m_tdata[63:32] !== e.extra_val)
                    report("extrapolated_value", m_tdata[63:32], e.extra_val);
                if (m_tdata[95:64] !== e.diff_val)
                    report("difference", m_tdata[95:64], e.diff_val);
                if (m_tdata[158:96] !== e.total)
                    report("movement_total", m_tdata[158:96], e.total);
                if (m_tlast !== e.is_last)
                    report("is_last", m_tlast, e.is_last);
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        tau_q    = REG_RESET;
        sigma_q  = REG_RESET;
        omega_q  = REG_RESET;
        move_acc = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_sweep();
        test_backpressure();
        test_full_rate();

        while (pending_updates.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
sv/pvu_pkg.sv
sv/pvu_div.sv
sv/pvu_dpath.sv
sv/pvu_ctrl.sv
sv/pdhg_vector_update_unit.sv
verif/pdhg_vector_update_unit_tb.sv
